FILE: hdl/sch_pkg.sv
// ----------------------------------------------------------------------------
// Serial connect handshake package
// Shared types, codes and small character helpers for the handshake block.
// ----------------------------------------------------------------------------
package sch_pkg;

  // Kind of an input word, carried on the input tuser bus.
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_BYTE   = 3'd1,
    MODE_RD_ERR = 3'd2,
    MODE_WR_ERR = 3'd3,
    MODE_TICK   = 3'd4
  } mode_e;

  // Final outcome of a handshake.
  typedef enum logic [2:0] {
    OC_CONNECTED = 3'd0,
    OC_READ_ERR  = 3'd1,
    OC_WRITE_ERR = 3'd2,
    OC_OVERFLOW  = 3'd3,
    OC_TIMEOUT   = 3'd4
  } outcome_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ATTEMPTS = 1'b1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] TimeoutReset  = 16'd5;
  localparam logic [3:0]  AttemptsReset = 4'd3;

  // Reply text that the server sends back.
  localparam logic [2:0] ReplyLen = 3'd6;

  // Result word handed to the output buffer.
  typedef struct packed {
    logic [7:0] passed_error;
    outcome_e   outcome;
    logic       finished;
    logic       send_solicitation;
  } result_t;

  localparam int unsigned OutDataW = 16;
  localparam int unsigned InDataW  = 16;

  function automatic logic [7:0] reply_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h53; // S
      3'd1:    c = 8'h45; // E
      3'd2:    c = 8'h52; // R
      3'd3:    c = 8'h56; // V
      3'd4:    c = 8'h45; // E
      3'd5:    c = 8'h52; // R
      default: c = 8'h53;
    endcase
    return c;
  endfunction

  // Only ASCII lower-case letters are folded.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hdl/serial_connect_handshake.sv
// ----------------------------------------------------------------------------
// Serial connect handshake
// Sends the client solicitation, watches the serial stream for the server
// reply and reports how the handshake ended.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Bus fields (lowest bit first)
//  s_axis    in         tuser: mode; tdata: rx_byte, error_code
//  m_axis    out        tdata: send_solicitation, finished, outcome,
//                       passed_error, three zero bits
//  cfg       in         cfg_idx_i 0 timeout_ticks, 1 max_attempts
//
// Each accepted word lands in the input register and is processed once the
// result buffer has room; its result, if the word causes one, goes through
// that buffer to m_axis. One word is accepted every cycle while it has room.
// The throughput is set by the two-entry result buffer: input stalls only
// when that buffer is full. Reset leaves the block idle with the timeout
// at five ticks and three attempts; no clearing pass is needed.
module serial_connect_handshake #(
  parameter int unsigned BUFFER_SIZE = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [sch_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sch_pkg::CfgDataW-1:0]  cfg_data_i,
  // Input words.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sch_pkg::InDataW-1:0]   s_axis_tdata,   // rx_byte, error_code
  input  logic [2:0]                    s_axis_tuser,   // mode
  // Result words.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sch_pkg::OutDataW-1:0]  m_axis_tdata    // send_solicitation, finished,
                                                        // outcome, passed_error
);

  logic             res_valid;
  logic             res_space;
  sch_pkg::result_t res;
  sch_pkg::result_t out_res;

  // The core holds the input register and the handshake state; it only
  // advances a word when the result buffer has room for its result.
  sch_core #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_mode_i       (s_axis_tuser),
    .in_rx_byte_i    (s_axis_tdata[7:0]),
    .in_error_code_i (s_axis_tdata[15:8]),
    .res_space_i     (res_space),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // The result buffer parts the core from the output stall.
  sch_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (res_space),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.passed_error, out_res.outcome,
                         out_res.finished, out_res.send_solicitation};

  // A result is only produced when the buffer can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_space)
    else $error("result pushed into a full buffer");

  // A finishing result never also asks for a solicitation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.finished) |-> !out_res.send_solicitation)
    else $error("finished result also requests a solicitation");

  // An error code is only forwarded with a read or write error outcome.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.passed_error != 8'd0) |->
      (out_res.finished && (out_res.outcome == sch_pkg::OC_READ_ERR ||
                            out_res.outcome == sch_pkg::OC_WRITE_ERR)))
    else $error("error code forwarded with a wrong outcome");

  // Without a finished flag the outcome field stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_res.finished) |-> (out_res.outcome == sch_pkg::OC_CONNECTED))
    else $error("outcome set on a non-final result");

endmodule

FILE: hdl/sch_core.sv
// ----------------------------------------------------------------------------
// Handshake core
// Input word register, handshake state and the single-pass step logic.
// ----------------------------------------------------------------------------
module sch_core #(
  parameter int unsigned BUFFER_SIZE = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sch_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sch_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     in_mode_i,
  input  logic [7:0]                     in_rx_byte_i,
  input  logic [7:0]                     in_error_code_i,
  input  logic                           res_space_i,
  output logic                           res_valid_o,
  output sch_pkg::result_t               res_o
);

  localparam int unsigned CntW = $clog2(BUFFER_SIZE + 1);
  localparam logic [CntW-1:0] BufLimit = CntW'(BUFFER_SIZE);

  logic [15:0] timeout_q;
  logic [3:0]  attempts_max_q;

  logic              item_valid_q;
  sch_pkg::mode_e    item_mode_q;
  logic [7:0]        item_rx_q;
  logic [7:0]        item_err_q;

  logic              active_q, active_d;
  logic [2:0]        match_q, match_d;
  logic [CntW-1:0]   bytes_q, bytes_d;
  logic [3:0]        attempts_q, attempts_d;
  logic [15:0]       ticks_q, ticks_d;

  logic              advance;
  logic              has_res;
  sch_pkg::result_t  res;
  logic [7:0]        ch;
  logic [2:0]        match_inc;
  logic [15:0]       ticks_inc;

  assign advance    = item_valid_q && res_space_i;
  assign in_ready_o = !item_valid_q || res_space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q      <= sch_pkg::TimeoutReset;
      attempts_max_q <= sch_pkg::AttemptsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sch_pkg::CFG_TIMEOUT:  timeout_q      <= cfg_data_i[15:0];
        sch_pkg::CFG_ATTEMPTS: attempts_max_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_mode_q <= sch_pkg::mode_e'(in_mode_i);
      item_rx_q   <= in_rx_byte_i;
      item_err_q  <= in_error_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      match_q    <= '0;
      bytes_q    <= '0;
      attempts_q <= '0;
      ticks_q    <= '0;
    end else if (advance) begin
      active_q   <= active_d;
      match_q    <= match_d;
      bytes_q    <= bytes_d;
      attempts_q <= attempts_d;
      ticks_q    <= ticks_d;
    end
  end

  assign ch        = sch_pkg::fold_upper(item_rx_q);
  assign ticks_inc = ticks_q + 16'd1;

  always_comb begin
    active_d   = active_q;
    match_d    = match_q;
    bytes_d    = bytes_q;
    attempts_d = attempts_q;
    ticks_d    = ticks_q;
    has_res    = 1'b0;
    res        = '0;
    match_inc  = '0;
    if (item_mode_q == sch_pkg::MODE_START) begin
      active_d   = 1'b1;
      match_d    = '0;
      bytes_d    = '0;
      attempts_d = 4'd1;
      ticks_d    = '0;
      has_res    = 1'b1;
      res.send_solicitation = 1'b1;
    end else if (active_q) begin
      case (item_mode_q) inside
        sch_pkg::MODE_BYTE: begin
          if (bytes_q >= BufLimit) begin
            active_d     = 1'b0;
            has_res      = 1'b1;
            res.finished = 1'b1;
            res.outcome  = sch_pkg::OC_OVERFLOW;
          end else begin
            bytes_d = bytes_q + CntW'(1);
            if (match_q < sch_pkg::ReplyLen && ch == sch_pkg::reply_char(match_q)) begin
              match_inc = match_q + 3'd1;
            end else begin
              match_inc = (ch == sch_pkg::reply_char(3'd0)) ? 3'd1 : 3'd0;
            end
            match_d = match_inc;
            if (match_inc >= sch_pkg::ReplyLen) begin
              match_d      = '0;
              active_d     = 1'b0;
              has_res      = 1'b1;
              res.finished = 1'b1;
              res.outcome  = sch_pkg::OC_CONNECTED;
            end
          end
        end
        sch_pkg::MODE_RD_ERR, sch_pkg::MODE_WR_ERR: begin
          if (item_err_q != 8'd0) begin
            active_d         = 1'b0;
            has_res          = 1'b1;
            res.finished     = 1'b1;
            res.passed_error = item_err_q;
            res.outcome      = (item_mode_q == sch_pkg::MODE_RD_ERR) ?
                               sch_pkg::OC_READ_ERR : sch_pkg::OC_WRITE_ERR;
          end
        end
        sch_pkg::MODE_TICK: begin
          ticks_d = ticks_inc;
          if (ticks_inc >= timeout_q) begin
            ticks_d = '0;
            has_res = 1'b1;
            if (attempts_q < attempts_max_q) begin
              attempts_d            = attempts_q + 4'd1;
              res.send_solicitation = 1'b1;
            end else begin
              active_d     = 1'b0;
              res.finished = 1'b1;
              res.outcome  = sch_pkg::OC_TIMEOUT;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid_o = advance && has_res;
  assign res_o       = res;

endmodule

FILE: hdl/sch_out_buf.sv
// ----------------------------------------------------------------------------
// Handshake result buffer
// Two-entry result queue that decouples the core from the output stall.
// ----------------------------------------------------------------------------
module sch_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sch_pkg::result_t push_data_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sch_pkg::result_t out_data_o
);

  sch_pkg::result_t ent_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && out_ready_i;
  assign space_o     = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = ent_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
